/* rtl/ir_light_curtain_scanner_top_assert.svh */
// assertion macros for the light-curtain scanner
`ifndef IR_LIGHT_CURTAIN_SCANNER_TOP_ASSERT_SVH
`define IR_LIGHT_CURTAIN_SCANNER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ILCS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scanner check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ILCS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scanner check failed: next-cycle implication");

`endif

/* rtl/ilcs_pkg.sv */
`default_nettype none
package ilcs_pkg;

	localparam int MAX_LEDS   = 32;
	localparam int CH_W       = $clog2(MAX_LEDS);
	localparam int SAMPLE_W   = 10;
	localparam int SUM_W      = 16;
	localparam int NUM_W      = 6;
	localparam int CONE_W     = 2;
	localparam int PHASE_W    = 3;
	localparam int PULSE_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// phase codes
	localparam logic [PHASE_W-1:0] PH_TUNE1  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_TUNE2  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_NOISE  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_SIGNAL = 3'd3;
	localparam logic [PHASE_W-1:0] PH_RUN    = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_LEDS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONE_HALF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_THR  = 2'd3;

	// register reset values
	localparam logic [NUM_W-1:0]      RST_NUM_LEDS  = 6'd24;
	localparam logic [CONE_W-1:0]     RST_CONE_HALF = 2'd2;
	localparam logic [SAMPLE_W-1:0]   RST_MARGIN    = 10'd30;
	localparam logic [SAMPLE_W-1:0]   RST_GAIN_THR  = 10'd512;

	typedef struct packed {
		logic [CH_W-1:0]    next_led;
		logic               sync_level;
		logic [PULSE_W-1:0] sync_pulses;
		logic               high_gain;
		logic [PHASE_W-1:0] phase;
		logic               beam_clear;
		logic               verdict_valid;
		logic [CH_W-1:0]    channel;
	} result_t;

endpackage
`default_nettype wire

/* rtl/ilcs_if.sv */
`default_nettype none
// sample request channel
interface ilcs_sample_if;
	import ilcs_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// result request channel
interface ilcs_result_if;
	import ilcs_pkg::*;
	logic               valid;
	logic               ready;
	logic [CH_W-1:0]    next_led;
	logic               sync_level;
	logic [PULSE_W-1:0] sync_pulses;
	logic               high_gain;
	logic [PHASE_W-1:0] phase;
	logic               beam_clear;
	logic               verdict_valid;
	logic [CH_W-1:0]    channel;
	modport source (output valid, output next_led, output sync_level, output sync_pulses,
		output high_gain, output phase, output beam_clear, output verdict_valid,
		output channel, input ready);
	modport sink (input valid, input next_led, input sync_level, input sync_pulses,
		input high_gain, input phase, input beam_clear, input verdict_valid,
		input channel, output ready);
endinterface

// configuration write channel
interface ilcs_cfg_if;
	import ilcs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/ir_light_curtain_scanner_top.sv */
// channel   dir  width  content
// samples   in   10     sample
// results   out  19     next_led sync_level sync_pulses high_gain phase
//                       beam_clear verdict_valid channel
// cfg       in   2+10   index, data (always ready)
//
// one sample per cycle unless both queue entries are full; each sample's result is
// formed in the cycle it is taken and offered from the next cycle out of a two-entry
// output queue, so one result waiting does not stop the next sample
// thresholds live in a 32x16 synchronous memory, read every cycle at the channel of
// the next sample; a write to the same entry is forwarded into the read register
// arst_n clears control state and the registers; the threshold memory is not cleared
// samples stall only while both queue entries are waiting for the consumer
`default_nettype none
`include "ir_light_curtain_scanner_top_assert.svh"
module ir_light_curtain_scanner_top (
	input  wire         clk,
	input  wire         arst_n,
	ilcs_sample_if.sink samples,
	ilcs_result_if.source results,
	ilcs_cfg_if.sink    cfg
);
	import ilcs_pkg::*;

	// configuration registers
	logic [NUM_W-1:0]    num_leds_q;
	logic [CONE_W-1:0]   cone_half_q;
	logic [SAMPLE_W-1:0] margin_q;
	logic [SAMPLE_W-1:0] gain_thr_q;

	// sequencer state
	logic [PHASE_W-1:0]  mode_q;
	logic                gain_q;
	logic [CH_W-1:0]     chan_q;
	logic [CH_W-1:0]     pos_q;
	logic [SUM_W-1:0]    noise_q;
	logic [SUM_W-1:0]    sig_q;

	// threshold memory
	logic [SUM_W-1:0]    thr_mem [MAX_LEDS];
	logic [SUM_W-1:0]    thr_q;
	logic                mem_we;
	logic [SUM_W-1:0]    mem_wdata;
	logic [CH_W-1:0]     rd_addr;

	// output queue
	result_t             ent_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          cnt_q;

	logic                accept;
	logic                pop;
	result_t             res;

	logic [PHASE_W-1:0]  mode_n;
	logic                gain_n;
	logic [CH_W-1:0]     chan_n;
	logic [CH_W-1:0]     pos_n;
	logic [SUM_W-1:0]    noise_n;
	logic [SUM_W-1:0]    sig_n;
	logic [PULSE_W-1:0]  pulses;
	logic                clear;
	logic                verdict;

	logic [NUM_W-1:0]    n_eff;
	logic [NUM_W-1:0]    n_m1;
	logic [CH_W-1:0]     last;
	logic [SUM_W-1:0]    noise_sum;
	logic [SUM_W-1:0]    sig_sum;
	logic                cone_end;
	logic [NUM_W-1:0]    c_inc;
	logic [CH_W-1:0]     c_adv;

	// first photodiode of a channel's cone
	function automatic logic [CH_W-1:0] cone_start(input logic [CH_W-1:0] c,
			input logic [CONE_W-1:0] h);
		logic [CH_W-1:0] hw;
		hw = {{(CH_W-CONE_W){1'b0}}, h};
		return (c > hw) ? c - hw : '0;
	endfunction

	// last photodiode of a channel's cone, clamped to the last channel
	function automatic logic [CH_W-1:0] cone_stop(input logic [CH_W-1:0] c,
			input logic [CONE_W-1:0] h, input logic [CH_W-1:0] lst);
		logic [CH_W:0] top;
		top = {1'b0, c} + {{(CH_W+1-CONE_W){1'b0}}, h};
		return (top > {1'b0, lst}) ? lst : top[CH_W-1:0];
	endfunction

	assign accept = samples.valid && samples.ready;
	assign pop    = results.valid && results.ready;
	assign samples.ready = (cnt_q != 2'd2);
	assign cfg.ready = 1'b1;

	// effective channel count
	always_comb begin
		if (num_leds_q == '0) begin
			n_eff = NUM_W'(1);
		end else if (num_leds_q > NUM_W'(MAX_LEDS)) begin
			n_eff = NUM_W'(MAX_LEDS);
		end else begin
			n_eff = num_leds_q;
		end
		n_m1 = n_eff - NUM_W'(1);
		last = n_m1[CH_W-1:0];
	end

	// next state and result
	always_comb begin
		noise_sum = noise_q + {{(SUM_W-SAMPLE_W){1'b0}}, samples.sample};
		sig_sum   = sig_q + {{(SUM_W-SAMPLE_W){1'b0}}, samples.sample};
		cone_end  = (pos_q >= cone_stop(chan_q, cone_half_q, last));
		c_inc     = {1'b0, chan_q} + NUM_W'(1);
		c_adv     = (c_inc >= n_eff) ? '0 : c_inc[CH_W-1:0];
		mode_n    = mode_q;
		gain_n    = gain_q;
		chan_n    = chan_q;
		pos_n     = pos_q;
		noise_n   = noise_q;
		sig_n     = sig_q;
		pulses    = '0;
		clear     = 1'b0;
		verdict   = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = sig_sum - noise_q - {{(SUM_W-SAMPLE_W){1'b0}}, margin_q};
		unique case (mode_q)
			PH_TUNE1: begin
				if (samples.sample > gain_thr_q) begin
					pulses  = PULSE_W'(1);
					mode_n  = PH_NOISE;
					chan_n  = '0;
					pos_n   = '0;
					noise_n = '0;
					sig_n   = '0;
				end else begin
					pulses = PULSE_W'(2);
					mode_n = PH_TUNE2;
				end
			end
			PH_TUNE2: begin
				if (samples.sample <= gain_thr_q) gain_n = 1'b1;
				pulses  = PULSE_W'(1);
				mode_n  = PH_NOISE;
				chan_n  = '0;
				pos_n   = '0;
				noise_n = '0;
				sig_n   = '0;
			end
			PH_NOISE: begin
				noise_n = noise_sum;
				if (cone_end) begin
					mode_n = PH_SIGNAL;
					pos_n  = cone_start(chan_q, cone_half_q);
				end else begin
					pos_n = pos_q + CH_W'(1);
				end
			end
			PH_SIGNAL: begin
				sig_n = sig_sum;
				if (cone_end) begin
					mem_we  = 1'b1;
					noise_n = '0;
					sig_n   = '0;
					if (c_inc >= n_eff) begin
						pulses = PULSE_W'(1);
						mode_n = PH_RUN;
						chan_n = '0;
						pos_n  = '0;
					end else begin
						mode_n = PH_NOISE;
						chan_n = c_inc[CH_W-1:0];
						pos_n  = cone_start(c_inc[CH_W-1:0], cone_half_q);
					end
				end else begin
					pos_n = pos_q + CH_W'(1);
				end
			end
			PH_RUN: begin
				if (cone_end) begin
					verdict = 1'b1;
					sig_n   = '0;
					if (sig_sum > thr_q) begin
						clear  = 1'b1;
						pulses = PULSE_W'(1);
						chan_n = c_adv;
					end
					pos_n = cone_start(chan_n, cone_half_q);
				end else begin
					sig_n = sig_sum;
					pos_n = pos_q + CH_W'(1);
				end
			end
			default: begin
				mode_n = PH_TUNE1;
				pos_n  = '0;
			end
		endcase
		res.next_led      = pos_n;
		res.sync_level    = (mode_n != PH_NOISE);
		res.sync_pulses   = pulses;
		res.high_gain     = gain_n;
		res.phase         = mode_n;
		res.beam_clear    = clear;
		res.verdict_valid = verdict;
		res.channel       = chan_n;
		rd_addr = accept ? chan_n : chan_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_leds_q  <= RST_NUM_LEDS;
			cone_half_q <= RST_CONE_HALF;
			margin_q    <= RST_MARGIN;
			gain_thr_q  <= RST_GAIN_THR;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_NUM_LEDS:  num_leds_q  <= cfg.data[NUM_W-1:0];
				REG_CONE_HALF: cone_half_q <= cfg.data[CONE_W-1:0];
				REG_MARGIN:    margin_q    <= cfg.data;
				REG_GAIN_THR:  gain_thr_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequencer state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= PH_TUNE1;
			gain_q  <= 1'b0;
			chan_q  <= '0;
			pos_q   <= '0;
			noise_q <= '0;
			sig_q   <= '0;
		end else if (accept) begin
			mode_q  <= mode_n;
			gain_q  <= gain_n;
			chan_q  <= chan_n;
			pos_q   <= pos_n;
			noise_q <= noise_n;
			sig_q   <= sig_n;
		end
	end

	// threshold memory with write forwarding into the read register
	always_ff @(posedge clk) begin
		if (accept && mem_we) thr_mem[chan_q] <= mem_wdata;
		if (accept && mem_we && (chan_q == rd_addr)) begin
			thr_q <= mem_wdata;
		end else begin
			thr_q <= thr_mem[rd_addr];
		end
	end

	// output queue payload
	always_ff @(posedge clk) begin
		if (accept) ent_q[wr_ptr_q] <= res;
	end

	// output queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (accept) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({accept, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign results.valid         = (cnt_q != 2'd0);
	assign results.next_led      = ent_q[rd_ptr_q].next_led;
	assign results.sync_level    = ent_q[rd_ptr_q].sync_level;
	assign results.sync_pulses   = ent_q[rd_ptr_q].sync_pulses;
	assign results.high_gain     = ent_q[rd_ptr_q].high_gain;
	assign results.phase         = ent_q[rd_ptr_q].phase;
	assign results.beam_clear    = ent_q[rd_ptr_q].beam_clear;
	assign results.verdict_valid = ent_q[rd_ptr_q].verdict_valid;
	assign results.channel       = ent_q[rd_ptr_q].channel;

	// checks
	`ILCS_ASSERT_IMP(a_queue_bound, 1'b1, cnt_q <= 2'd2)
	`ILCS_ASSERT_IMP(a_write_in_signal, accept && mem_we, mode_q == PH_SIGNAL)
	`ILCS_ASSERT_IMP(a_verdict_in_run, accept && res.verdict_valid, mode_q == PH_RUN)
	`ILCS_ASSERT_NXT(a_full_after_push, accept && !pop && cnt_q == 2'd1, !samples.ready)

endmodule
`default_nettype wire

/* sim/tb_ir_light_curtain_scanner_top.sv */
module tb_ir_light_curtain_scanner_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ilcs_pkg::*;

	localparam int ITEM_GOAL    = 1300;
	localparam int TAIL_ITEMS   = 150;
	localparam int LIMIT_CYCLES = 200000;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

	typedef struct {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	// scanner predictor with its own copy of registers, sequencer state and thresholds
	class curtain_scoreboard;
		logic [NUM_W-1:0]    num_leds;
		logic [CONE_W-1:0]   cone_half;
		logic [SAMPLE_W-1:0] margin;
		logic [SAMPLE_W-1:0] gain_thr;
		logic [PHASE_W-1:0]  mode;
		logic                gain;
		logic [CH_W-1:0]     chan;
		logic [CH_W-1:0]     pos;
		logic [SUM_W-1:0]    noise_sum;
		logic [SUM_W-1:0]    sig_sum;
		logic [SUM_W-1:0]    thr_table [MAX_LEDS];
		result_t             pending_results [$];
		int                  mismatches;

		function new();
			num_leds   = RST_NUM_LEDS;
			cone_half  = RST_CONE_HALF;
			margin     = RST_MARGIN;
			gain_thr   = RST_GAIN_THR;
			mode       = PH_TUNE1;
			gain       = 1'b0;
			chan       = '0;
			pos        = '0;
			noise_sum  = '0;
			sig_sum    = '0;
			mismatches = 0;
			foreach (thr_table[i]) thr_table[i] = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_NUM_LEDS:  num_leds = data[NUM_W-1:0];
				REG_CONE_HALF: cone_half = data[CONE_W-1:0];
				REG_MARGIN:    margin = data[SAMPLE_W-1:0];
				REG_GAIN_THR:  gain_thr = data[SAMPLE_W-1:0];
				default:       ;
			endcase
		endfunction

		// channel count saturated to the supported range
		function int led_count();
			int n;
			n = int'(num_leds);
			if (n < 1) n = 1;
			if (n > MAX_LEDS) n = MAX_LEDS;
			return n;
		endfunction

		function int cone_lo(int c);
			return (c > int'(cone_half)) ? c - int'(cone_half) : 0;
		endfunction

		function int cone_hi(int c);
			int last;
			last = led_count() - 1;
			return (c + int'(cone_half) > last) ? last : c + int'(cone_half);
		endfunction

		function void open_noise(int c);
			mode      = PH_NOISE;
			chan      = CH_W'(c);
			pos       = CH_W'(cone_lo(c));
			noise_sum = '0;
			sig_sum   = '0;
		endfunction

		// advance the sequencer by one sample and queue the result it gives
		function void take_sample(logic [SAMPLE_W-1:0] s);
			result_t            want;
			int                 c;
			int                 n;
			logic [PULSE_W-1:0] pulses;
			logic               clr;
			logic               vld;
			c      = int'(chan);
			n      = led_count();
			pulses = '0;
			clr    = 1'b0;
			vld    = 1'b0;
			case (mode)
				PH_TUNE1: begin
					if (s > gain_thr) begin
						pulses = 2'd1;
						open_noise(0);
					end else begin
						pulses = 2'd2;
						mode   = PH_TUNE2;
					end
				end
				PH_TUNE2: begin
					if (s <= gain_thr) gain = 1'b1;
					pulses = 2'd1;
					open_noise(0);
				end
				PH_NOISE: begin
					noise_sum = noise_sum + s;
					if (int'(pos) >= cone_hi(c)) begin
						mode = PH_SIGNAL;
						pos  = CH_W'(cone_lo(c));
					end else begin
						pos = pos + 1'b1;
					end
				end
				PH_SIGNAL: begin
					sig_sum = sig_sum + s;
					if (int'(pos) >= cone_hi(c)) begin
						thr_table[c] = sig_sum - noise_sum - margin;
						noise_sum    = '0;
						sig_sum      = '0;
						if (c + 1 >= n) begin
							pulses = 2'd1;
							mode   = PH_RUN;
							chan   = '0;
							pos    = CH_W'(cone_lo(0));
						end else begin
							open_noise(c + 1);
						end
					end else begin
						pos = pos + 1'b1;
					end
				end
				PH_RUN: begin
					sig_sum = sig_sum + s;
					if (int'(pos) >= cone_hi(c)) begin
						vld = 1'b1;
						if (sig_sum > thr_table[c]) begin
							clr    = 1'b1;
							pulses = 2'd1;
							chan   = (c + 1 >= n) ? '0 : CH_W'(c + 1);
						end
						sig_sum = '0;
						pos     = CH_W'(cone_lo(int'(chan)));
					end else begin
						pos = pos + 1'b1;
					end
				end
				default: begin
					mode = PH_TUNE1;
					pos  = '0;
				end
			endcase
			want.next_led      = pos;
			want.sync_level    = (mode != PH_NOISE);
			want.sync_pulses   = pulses;
			want.high_gain     = gain;
			want.phase         = mode;
			want.beam_clear    = clr;
			want.verdict_valid = vld;
			want.channel       = chan;
			pending_results.push_back(want);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request outstanding, expected none, got %h",
					$time, got);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("next_led", 8'(want.next_led), 8'(got.next_led));
			compare_field("sync_level", 8'(want.sync_level), 8'(got.sync_level));
			compare_field("sync_pulses", 8'(want.sync_pulses), 8'(got.sync_pulses));
			compare_field("high_gain", 8'(want.high_gain), 8'(got.high_gain));
			compare_field("phase", 8'(want.phase), 8'(got.phase));
			compare_field("beam_clear", 8'(want.beam_clear), 8'(got.beam_clear));
			compare_field("verdict_valid", 8'(want.verdict_valid), 8'(got.verdict_valid));
			compare_field("channel", 8'(want.channel), 8'(got.channel));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ilcs_sample_if smp_if();
	ilcs_result_if res_if();
	ilcs_cfg_if    cfg_if();

	ir_light_curtain_scanner_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp_if),
		.results (res_if),
		.cfg     (cfg_if)
	);

	curtain_scoreboard sb;
	reg_write_t        reg_todo [$];
	int                noise_log [$];
	result_t           seen_results [$];
	int                sent;
	int                burst_left;
	int                rx_cycle;
	int                rx_mode;

	always #6 clk = ~clk;

	// receiver back-pressure: free running, random, or a fixed duty pattern
	always @(posedge clk) begin
		rx_cycle = rx_cycle + 1;
		if (rx_cycle % 96 == 0) rx_mode = $urandom_range(0, 2);
		case (rx_mode)
			0:       res_if.ready <= 1'b1;
			1:       res_if.ready <= ($urandom_range(0, 9) > 2);
			default: res_if.ready <= ((rx_cycle % 8) >= 5);
		endcase
	end

	// capture each accepted result request
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			seen_results.push_back('{res_if.next_led, res_if.sync_level, res_if.sync_pulses,
				res_if.high_gain, res_if.phase, res_if.beam_clear, res_if.verdict_valid,
				res_if.channel});
		end
	end

	// check on the falling edge, once the sample side has been noted
	always @(negedge clk) begin
		if (seen_results.size() > 0) sb.check_result(seen_results.pop_front());
	end

	// sample chosen from the predicted phase so calibration stays well formed
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int k;
		int dmin;
		int dmax;
		int base;
		int roll;
		logic [SAMPLE_W-1:0] s;
		k    = sb.cone_hi(int'(sb.chan)) - sb.cone_lo(int'(sb.chan)) + 1;
		// a channel beyond the count has an empty cone
		if (k < 1) k = 1;
		dmin = (int'(sb.margin) + k - 1) / k;
		dmax = (dmin + 100 > SAMPLE_MAX) ? SAMPLE_MAX : dmin + 100;
		case (sb.mode)
			PH_NOISE: begin
				// last channel gets a negative difference so its threshold wraps
				if (sb.chan == CH_W'(MAX_LEDS - 1)) s = $urandom_range(600, SAMPLE_MAX);
				else s = $urandom_range(0, SAMPLE_MAX - dmax);
				noise_log.push_back(int'(s));
			end
			PH_SIGNAL: begin
				base = (noise_log.size() > 0) ? noise_log.pop_front() : 0;
				if (sb.chan == CH_W'(MAX_LEDS - 1)) s = $urandom_range(0, 300);
				else s = SAMPLE_W'(base + int'($urandom_range(dmin, dmax)));
			end
			PH_RUN: begin
				roll = $urandom_range(0, 99);
				if (roll < 65) s = $urandom_range(720, SAMPLE_MAX);
				else if (roll < 85) s = $urandom_range(0, 100);
				else s = $urandom_range(0, SAMPLE_MAX);
			end
			default: s = $urandom_range(0, SAMPLE_MAX);
		endcase
		return s;
	endfunction

	// one sample request, sent in bursts with random gaps between them
	task automatic send_sample(logic [SAMPLE_W-1:0] s);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				smp_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		smp_if.valid  <= 1'b1;
		smp_if.sample <= s;
		do @(posedge clk); while (!smp_if.ready);
		sb.take_sample(s);
		sent++;
	endtask

	// stop sending and let every outstanding result drain
	task automatic settle();
		smp_if.valid <= 1'b0;
		while (sb.pending_results.size() > 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// issue the queued register writes back to back
	task automatic apply_regs();
		reg_write_t w;
		while (reg_todo.size() > 0) begin
			w = reg_todo.pop_front();
			cfg_if.valid <= 1'b1;
			cfg_if.index <= w.idx;
			cfg_if.data  <= w.data;
			do @(posedge clk); while (!cfg_if.ready);
			sb.set_reg(w.idx, w.data);
		end
		cfg_if.valid <= 1'b0;
	endtask

	// give-up timer
	initial begin
		#(LIMIT_CYCLES * 12);
		$display("tb_ir_light_curtain_scanner_top failed");
		$finish;
	end

	initial begin
		int ch;
		int phase_no;
		int pick;
		logic [NUM_W-1:0] leds;
		clk           = 1'b0;
		arst_n        = 1'b0;
		smp_if.valid  = 1'b0;
		smp_if.sample = '0;
		cfg_if.valid  = 1'b0;
		cfg_if.index  = REG_NUM_LEDS;
		cfg_if.data   = '0;
		res_if.ready  = 1'b0;
		rx_cycle      = 0;
		rx_mode       = 0;
		sent          = 0;
		burst_left    = 0;
		sb            = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// widest cone, largest margin, top gain threshold so both tune samples fail
		reg_todo.push_back('{REG_NUM_LEDS, CFG_DATA_W'(63)});
		reg_todo.push_back('{REG_CONE_HALF, CFG_DATA_W'(3)});
		reg_todo.push_back('{REG_MARGIN, CFG_DATA_W'(SAMPLE_MAX)});
		reg_todo.push_back('{REG_GAIN_THR, CFG_DATA_W'(SAMPLE_MAX)});
		apply_regs();
		send_sample('0);
		send_sample(SAMPLE_W'(SAMPLE_MAX));

		// calibrate all channels, reconfiguring only at channel boundaries
		while (sb.mode != PH_RUN) begin
			ch = int'(sb.chan);
			if (ch == 8) begin
				reg_todo.push_back('{REG_NUM_LEDS, CFG_DATA_W'(MAX_LEDS)});
				reg_todo.push_back('{REG_CONE_HALF, CFG_DATA_W'(0)});
				reg_todo.push_back('{REG_MARGIN, CFG_DATA_W'(0)});
			end else if (ch == 16) begin
				reg_todo.push_back('{REG_NUM_LEDS, CFG_DATA_W'(MAX_LEDS + 1)});
				reg_todo.push_back('{REG_CONE_HALF, CFG_DATA_W'(1)});
				reg_todo.push_back('{REG_MARGIN, CFG_DATA_W'($urandom_range(0, SAMPLE_MAX))});
			end else if (ch != 0 && $urandom_range(0, 3) == 0) begin
				reg_todo.push_back('{REG_CONE_HALF, CFG_DATA_W'($urandom_range(0, 3))});
				reg_todo.push_back('{REG_MARGIN, CFG_DATA_W'($urandom_range(0, SAMPLE_MAX))});
			end
			if (reg_todo.size() > 0) begin
				settle();
				apply_regs();
			end
			while (sb.mode != PH_RUN && sb.chan == CH_W'(ch)) send_sample(pick_sample());
		end

		// run phase in stretches, channel count kept below the wrapped channel
		phase_no = 0;
		while (sent < ITEM_GOAL - TAIL_ITEMS) begin
			settle();
			case (phase_no)
				0:       leds = NUM_W'(0);
				1:       leds = NUM_W'(1);
				2:       leds = NUM_W'(2);
				3:       leds = NUM_W'(MAX_LEDS - 1);
				default: leds = NUM_W'($urandom_range(0, MAX_LEDS - 1));
			endcase
			reg_todo.push_back('{REG_NUM_LEDS, CFG_DATA_W'(leds)});
			if (phase_no < 4 || $urandom_range(0, 1) == 0) begin
				reg_todo.push_back('{REG_CONE_HALF, CFG_DATA_W'($urandom_range(0, 3))});
			end
			if (phase_no == 4) begin
				reg_todo.push_back('{REG_GAIN_THR, CFG_DATA_W'(0)});
			end else if ($urandom_range(0, 3) == 0) begin
				pick = $urandom_range(0, 2);
				reg_todo.push_back('{REG_GAIN_THR, CFG_DATA_W'($urandom_range(0, SAMPLE_MAX))});
				reg_todo.push_back('{REG_MARGIN,
					CFG_DATA_W'(pick == 0 ? 0 : pick == 1 ? SAMPLE_MAX : $urandom_range(0, SAMPLE_MAX))});
			end
			apply_regs();
			repeat ($urandom_range(10, 60)) send_sample(pick_sample());
			phase_no++;
		end

		// full channel count: the wrapped threshold channel ends up blocked
		settle();
		reg_todo.push_back('{REG_NUM_LEDS, CFG_DATA_W'(MAX_LEDS)});
		apply_regs();
		repeat (TAIL_ITEMS) send_sample(pick_sample());

		settle();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("tb_ir_light_curtain_scanner_top passed");
		end else begin
			$display("tb_ir_light_curtain_scanner_top failed");
		end
		$finish;
	end

endmodule
